// File: rtl/core/tql_pkg.sv
// Shared constants and register codes for the Q-table update engine.
package tql_pkg;

  localparam int STATE_BITS     = 4;
  localparam int ACTION_BITS    = 2;
  localparam int REWARD_BITS    = 16;
  localparam int VALUE_BITS     = 16;
  localparam int RATE_BITS      = 16;
  localparam int FRAC_SHIFT     = 16;
  localparam int CFG_INDEX_BITS = 8;

  localparam logic [RATE_BITS-1:0] LR_RESET       = 16'd58982;
  localparam logic [RATE_BITS-1:0] DISCOUNT_RESET = 16'd58982;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LEARNING_RATE = 8'd0,
    REG_DISCOUNT      = 8'd1
  } reg_index_t;

endpackage

// File: rtl/core/tql_if.sv
// Channel interfaces: transition words in, result words out, register writes.
interface tql_item_if;
  logic                                   valid;
  logic                                   ready;
  logic [tql_pkg::STATE_BITS-1:0]         current_state;
  logic [tql_pkg::ACTION_BITS-1:0]        action;
  logic signed [tql_pkg::REWARD_BITS-1:0] reward;
  logic [tql_pkg::STATE_BITS-1:0]         next_state;

  modport source (output valid, current_state, action, reward, next_state, input ready);
  modport sink   (input valid, current_state, action, reward, next_state, output ready);
endinterface

interface tql_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tql_pkg::VALUE_BITS-1:0] updated_value;
  logic [tql_pkg::ACTION_BITS-1:0]       best_next_action;
  logic signed [tql_pkg::VALUE_BITS-1:0] best_next_value;
  logic                                  saturated;

  modport source (output valid, updated_value, best_next_action, best_next_value, saturated,
                  input ready);
  modport sink   (input valid, updated_value, best_next_action, best_next_value, saturated,
                  output ready);
endinterface

interface tql_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tql_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [tql_pkg::RATE_BITS-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/tabular_q_learning_update.sv
// A result word is registered at the write back after EVAL, DISC, DELTA and WRITE;
// a new transition is taken only in IDLE, so the row reads, the discount multiply,
// the learning-rate multiply and the row write back run in turn for each word.
// Reset: rates return to their reset values, then a sweep over all NUM_STATES rows
// zeroes the value table; no transition is taken during the sweep.
module tabular_q_learning_update #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_ACTIONS = 4
) (
  input  logic                clk,
  input  logic                rst,
  tql_item_if.sink            transition,
  tql_result_if.source        result,
  tql_cfg_if.sink             cfg
);

  localparam int VB       = tql_pkg::VALUE_BITS;
  localparam int RB       = tql_pkg::RATE_BITS;
  localparam int AW       = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int ACW      = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
  localparam int ROW_BITS = NUM_ACTIONS * VB;
  localparam int DPROD    = RB + 1 + VB;
  localparam int TGT_BITS = VB + 3;
  localparam int LPROD    = RB + 1 + TGT_BITS;
  localparam int DLT_BITS = LPROD - tql_pkg::FRAC_SHIFT;
  localparam int NV_BITS  = DLT_BITS + 1;

  localparam logic signed [NV_BITS-1:0] VMAX = NV_BITS'((64'sd1 <<< (VB - 1)) - 64'sd1);
  localparam logic signed [NV_BITS-1:0] VMIN = NV_BITS'(-(64'sd1 <<< (VB - 1)));

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_EVAL  = 6'b000100,
    ST_DISC  = 6'b001000,
    ST_DELTA = 6'b010000,
    ST_WRITE = 6'b100000
  } state_t;

  typedef logic [NUM_ACTIONS-1:0][VB-1:0] row_t;

  state_t state, state_next;

  logic [RB-1:0] learning_rate;
  logic [RB-1:0] discount;

  logic [AW-1:0]             clr_addr;
  logic [AW-1:0]             s_addr;
  logic [ACW-1:0]            a_idx;
  logic signed [VB-1:0]      reward;
  logic signed [VB-1:0]      best_value;
  logic [ACW-1:0]            best_action;
  logic signed [VB-1:0]      q_value;
  logic signed [TGT_BITS-1:0] target;
  logic signed [LPROD-1:0]   delta_prod;

  logic                      out_valid;
  logic signed [VB-1:0]      out_value;
  logic [tql_pkg::ACTION_BITS-1:0] out_action;
  logic signed [VB-1:0]      out_best;
  logic                      out_sat;

  logic                      accept;
  logic [AW-1:0]             rd_s, rd_ns;
  logic [ACW-1:0]            act_mod;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [ROW_BITS-1:0]       ram_wdata;
  logic [ROW_BITS-1:0]       rdata_s, rdata_ns;
  row_t                      row_s, row_ns, row_new;

  logic signed [VB-1:0]      eval_best;
  logic [ACW-1:0]            eval_act;
  logic signed [DPROD-1:0]   disc_prod;
  logic signed [VB:0]        disc;
  logic signed [DLT_BITS-1:0] delta;
  logic signed [NV_BITS-1:0] nv_wide;
  logic signed [VB-1:0]      nv;
  logic                      nv_sat;
  logic                      wb_go;

  // Index reduction for out-of-range states and actions.
  assign rd_s    = AW'(32'(transition.current_state) % NUM_STATES);
  assign rd_ns   = AW'(32'(transition.next_state) % NUM_STATES);
  assign act_mod = ACW'(32'(transition.action) % NUM_ACTIONS);

  assign transition.ready = (state == ST_IDLE);
  assign accept           = transition.valid && transition.ready;
  assign cfg.ready        = 1'b1;

  // Two copies of the table so both rows come back from the same read.
  tql_ram #(.WIDTH(ROW_BITS), .DEPTH(NUM_STATES)) u_ram_cur (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (rd_s),
    .rdata (rdata_s)
  );

  tql_ram #(.WIDTH(ROW_BITS), .DEPTH(NUM_STATES)) u_ram_next (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (rd_ns),
    .rdata (rdata_ns)
  );

  assign row_s  = rdata_s;
  assign row_ns = rdata_ns;

  // Argmax against the running maximum; lowest index wins ties.
  always_comb begin
    eval_best = $signed(row_ns[0]);
    eval_act  = '0;
    for (int i = 1; i < NUM_ACTIONS; i++) begin
      if ($signed(row_ns[i]) > eval_best) begin
        eval_best = $signed(row_ns[i]);
        eval_act  = ACW'(i);
      end
    end
  end

  assign disc_prod = $signed({1'b0, discount}) * best_value;
  assign disc      = disc_prod[DPROD-1:tql_pkg::FRAC_SHIFT];
  assign delta     = delta_prod[LPROD-1:tql_pkg::FRAC_SHIFT];
  assign nv_wide   = NV_BITS'(q_value) + NV_BITS'(delta);

  always_comb begin
    nv_sat = 1'b0;
    nv     = nv_wide[VB-1:0];
    if (nv_wide > VMAX) begin
      nv     = VMAX[VB-1:0];
      nv_sat = 1'b1;
    end else if (nv_wide < VMIN) begin
      nv     = VMIN[VB-1:0];
      nv_sat = 1'b1;
    end
  end

  always_comb begin
    row_new        = row_s;
    row_new[a_idx] = nv;
  end

  // Hold the write back until the output register can take the word.
  assign wb_go = (state == ST_WRITE) && (!out_valid || result.ready);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s_addr;
    ram_wdata = row_new;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (wb_go) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == AW'(NUM_STATES - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_EVAL;
      ST_EVAL:  state_next = ST_DISC;
      ST_DISC:  state_next = ST_DELTA;
      ST_DELTA: state_next = ST_WRITE;
      ST_WRITE: if (wb_go) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      out_valid     <= 1'b0;
      learning_rate <= tql_pkg::LR_RESET;
      discount      <= tql_pkg::DISCOUNT_RESET;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg.valid) begin
        unique case (cfg.index)
          tql_pkg::REG_LEARNING_RATE: learning_rate <= cfg.data;
          tql_pkg::REG_DISCOUNT:      discount      <= cfg.data;
          default:                    ;
        endcase
      end
      if (wb_go) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s_addr <= rd_s;
      a_idx  <= act_mod;
      reward <= transition.reward;
    end
    if (state == ST_EVAL) begin
      best_value  <= eval_best;
      best_action <= eval_act;
      q_value     <= $signed(row_s[a_idx]);
    end
    if (state == ST_DISC) begin
      target <= TGT_BITS'(reward) + TGT_BITS'(disc) - TGT_BITS'(q_value);
    end
    if (state == ST_DELTA) begin
      delta_prod <= $signed({1'b0, learning_rate}) * target;
    end
    if (wb_go) begin
      out_value  <= nv;
      out_action <= tql_pkg::ACTION_BITS'(best_action);
      out_best   <= best_value;
      out_sat    <= nv_sat;
    end
  end

  assign result.valid            = out_valid;
  assign result.updated_value    = out_value;
  assign result.best_next_action = out_action;
  assign result.best_next_value  = out_best;
  assign result.saturated        = out_sat;

  a_result_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_WRITE))
    else $error("result word appeared without a write back");

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || state == ST_WRITE))
    else $error("table written outside clear sweep or write back");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_sat) |->
      (out_value == VMAX[VB-1:0] || out_value == VMIN[VB-1:0]))
    else $error("saturated flag set with value off the limits");

endmodule

// File: rtl/core/tql_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tql_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
